// File: src/rhr_pkg.sv
// Package for the RGBA5551 hue rotation pipeline.
// Holds stage types, colour codes and fixed reciprocal constants.
// No dependencies.
package rhr_pkg;

	localparam int unsigned PIX_W = 16;
	localparam int unsigned CH_W  = 8;

	// c * 255 / 31 as a reciprocal multiply, exact for 5-bit c
	localparam logic [21:0] WIDEN_MUL   = 22'd2156535;
	localparam int unsigned WIDEN_SHIFT = 18;

	// deg / 60, exact for deg below 512
	localparam logic [9:0]  DEG_RECIP = 10'd547;
	localparam int unsigned DEG_SHIFT = 15;

	// v / 60, exact for v below 2**14 + 60
	localparam logic [14:0] X_RECIP = 15'd17477;
	localparam int unsigned X_SHIFT = 20;

	localparam logic [14:0] HALF_STEP = 15'd30;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} rhr_max_t;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW   = 3'd0,
		SEC_YELLOW_GREEN = 3'd1,
		SEC_GREEN_CYAN   = 3'd2,
		SEC_CYAN_BLUE    = 3'd3,
		SEC_BLUE_MAGENTA = 3'd4,
		SEC_MAGENTA_RED  = 3'd5
	} rhr_sector_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} rhr_adv_t;

	typedef struct packed {
		logic [PIX_W-1:0]       px;
		logic [CH_W-1:0]        mn;
		logic [CH_W-1:0]        d;
		logic signed [CH_W:0]   n;
		rhr_max_t               maxc;
		logic                   bypass;
	} rhr_s2_t;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [CH_W-1:0]  mn;
		logic [CH_W-1:0]  d;
		rhr_sector_t      sector;
		logic [14:0]      v;
		logic             bypass;
	} rhr_s4_t;

	function automatic logic [CH_W-1:0] widen5(input logic [4:0] c);
		logic [26:0] p;
		p = 27'(c) * 27'(WIDEN_MUL);
		return p[WIDEN_SHIFT +: CH_W];
	endfunction

endpackage

// File: src/rgba5551_hue_rotate.sv
// Top level of the RGBA5551 hue rotation pipeline: angle register,
// stage valids and advance chain. Depends on rhr_pkg, rhr_front,
// rhr_sector and rhr_rebuild.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------
//   pixel    | pix_valid, pix_stall | pixel_in  [15:0]
//   result   | res_valid, res_stall | pixel_out [15:0]
//   angle    | hue_we               | hue_wdata [8:0]
//
// Six register stages; one item a cycle unless res_stall holds the pipeline.
// The stages carry the widen multiply, the sector fold and the /60 multiply.
// Reset clears the stage valids and the angle register (angle 0).
// A stage holds while its successor holds; empty stages fill under a stall.
module rgba5551_hue_rotate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] pixel_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] pixel_out,
	input  logic        hue_we,
	input  logic [8:0]  hue_wdata
);

	logic [8:0] hue_q;
	logic [3:0] rot_q_q;
	logic [5:0] rot_r_q;

	logic [18:0] qprod;
	logic [3:0]  q_n;
	logic [8:0]  q60;
	logic [8:0]  r_n;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rhr_pkg::rhr_adv_t adv;

	rhr_pkg::rhr_s2_t d_s2;
	rhr_pkg::rhr_s4_t d_s4;

	always_comb begin
		qprod = 19'(hue_wdata) * 19'(rhr_pkg::DEG_RECIP);
		q_n   = qprod[rhr_pkg::DEG_SHIFT +: 4];
		q60   = (9'(q_n) << 6) - (9'(q_n) << 2);
		r_n   = hue_wdata - q60;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q   <= '0;
			rot_q_q <= '0;
			rot_r_q <= '0;
		end else if (hue_we) begin
			hue_q   <= hue_wdata;
			rot_q_q <= q_n;
			rot_r_q <= r_n[5:0];
		end
	end

	always_comb begin
		adv.s6 = !v_s6 || !res_stall;
		adv.s5 = !v_s5 || adv.s6;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= pix_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
			if (adv.s6) v_s6 <= v_s5;
		end
	end

	assign pix_stall = !adv.s1;
	assign res_valid = v_s6;

	rhr_front u_front (
		.clk      (clk),
		.adv      (adv),
		.pixel_in (pixel_in),
		.rot_zero (hue_q == 9'd0),
		.out_s2   (d_s2)
	);

	rhr_sector u_sector (
		.clk    (clk),
		.adv    (adv),
		.in_s2  (d_s2),
		.rot_q  (rot_q_q),
		.rot_r  (rot_r_q),
		.out_s4 (d_s4)
	);

	rhr_rebuild u_rebuild (
		.clk      (clk),
		.adv      (adv),
		.in_s4    (d_s4),
		.pixel_s6 (pixel_out)
	);

endmodule

// File: src/rhr_front.sv
// Front stages: widen the colour channels, then find max, min, chroma
// and the scaled hue offset. Depends on rhr_pkg.
module rhr_front (
	input  logic                    clk,
	input  rhr_pkg::rhr_adv_t       adv,
	input  logic [15:0]             pixel_in,
	input  logic                    rot_zero,
	output rhr_pkg::rhr_s2_t        out_s2
);

	logic [7:0]  r_s1, g_s1, b_s1;
	logic [15:0] px_s1;

	logic [7:0]        mx, mn;
	logic signed [8:0] n;
	rhr_pkg::rhr_max_t maxc;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			r_s1  <= rhr_pkg::widen5(pixel_in[15:11]);
			g_s1  <= rhr_pkg::widen5(pixel_in[10:6]);
			b_s1  <= rhr_pkg::widen5(pixel_in[5:1]);
			px_s1 <= pixel_in;
		end
	end

	always_comb begin
		mx = (r_s1 > g_s1) ? r_s1 : g_s1;
		mn = (r_s1 < g_s1) ? r_s1 : g_s1;
		if (b_s1 > mx) mx = b_s1;
		if (b_s1 < mn) mn = b_s1;
		if (mx == r_s1) begin
			maxc = rhr_pkg::MAX_RED;
			n    = $signed({1'b0, g_s1}) - $signed({1'b0, b_s1});
		end else if (mx == g_s1) begin
			maxc = rhr_pkg::MAX_GREEN;
			n    = $signed({1'b0, b_s1}) - $signed({1'b0, r_s1});
		end else begin
			maxc = rhr_pkg::MAX_BLUE;
			n    = $signed({1'b0, r_s1}) - $signed({1'b0, g_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			out_s2.px     <= px_s1;
			out_s2.mn     <= mn;
			out_s2.d      <= mx - mn;
			out_s2.n      <= n;
			out_s2.maxc   <= maxc;
			out_s2.bypass <= rot_zero || (mx == mn);
		end
	end

endmodule

// File: src/rhr_sector.sv
// Middle stages: rotate the scaled hue, find the sector and the numerator
// of the intermediate channel. Depends on rhr_pkg.
module rhr_sector (
	input  logic                clk,
	input  rhr_pkg::rhr_adv_t   adv,
	input  rhr_pkg::rhr_s2_t    in_s2,
	input  logic [3:0]          rot_q,
	input  logic [5:0]          rot_r,
	output rhr_pkg::rhr_s4_t    out_s4
);

	logic [15:0]        px_s3;
	logic [7:0]         mn_s3, d_s3;
	rhr_pkg::rhr_max_t  maxc_s3;
	logic               bypass_s3;
	logic signed [15:0] res_s3;
	logic [13:0]        d60_s3;

	logic signed [15:0] n_w;
	logic [13:0]        dprod;
	logic [13:0]        d_ext;

	logic               neg, ge;
	logic signed [15:0] d60_sx, w_full;
	logic [13:0]        w;
	logic [1:0]         inc;
	logic [4:0]         t;
	logic [4:0]         t_mod;
	rhr_pkg::rhr_sector_t sector;
	logic [14:0]        v;

	always_comb begin
		n_w   = 16'(in_s2.n);
		dprod = 14'(in_s2.d) * 14'(rot_r);
		d_ext = 14'(in_s2.d);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			px_s3     <= in_s2.px;
			mn_s3     <= in_s2.mn;
			d_s3      <= in_s2.d;
			maxc_s3   <= in_s2.maxc;
			bypass_s3 <= in_s2.bypass;
			res_s3    <= (n_w <<< 6) - (n_w <<< 2) + $signed({2'b00, dprod});
			d60_s3    <= (d_ext << 6) - (d_ext << 2);
		end
	end

	always_comb begin
		d60_sx = $signed({2'b00, d60_s3});
		neg    = res_s3[15];
		ge     = !neg && (res_s3[14:0] >= {1'b0, d60_s3});
		if (neg) begin
			w_full = res_s3 + d60_sx;
			inc    = 2'd0;
		end else if (ge) begin
			w_full = res_s3 - d60_sx;
			inc    = 2'd2;
		end else begin
			w_full = res_s3;
			inc    = 2'd1;
		end
		w = w_full[13:0];
		t = 5'({maxc_s3, 1'b0}) + 5'(rot_q) + 5'd5 + 5'(inc);
		if (t >= 5'd18)      t_mod = t - 5'd18;
		else if (t >= 5'd12) t_mod = t - 5'd12;
		else if (t >= 5'd6)  t_mod = t - 5'd6;
		else                 t_mod = t;
		sector = rhr_pkg::rhr_sector_t'(t_mod[2:0]);
		if (!t_mod[0]) v = {1'b0, w} + rhr_pkg::HALF_STEP;
		else           v = {1'b0, d60_s3} - {1'b0, w} + rhr_pkg::HALF_STEP;
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			out_s4.px     <= px_s3;
			out_s4.mn     <= mn_s3;
			out_s4.d      <= d_s3;
			out_s4.sector <= sector;
			out_s4.v      <= v;
			out_s4.bypass <= bypass_s3;
		end
	end

endmodule

// File: src/rhr_rebuild.sv
// Back stages: divide the numerator by 60, then place the channels by
// sector and pack the result pixel. Depends on rhr_pkg.
module rhr_rebuild (
	input  logic                clk,
	input  rhr_pkg::rhr_adv_t   adv,
	input  rhr_pkg::rhr_s4_t    in_s4,
	output logic [15:0]         pixel_s6
);

	logic [29:0]          xprod;
	logic [7:0]           x_s5;
	logic [15:0]          px_s5;
	logic [7:0]           mn_s5, d_s5;
	rhr_pkg::rhr_sector_t sector_s5;
	logic                 bypass_s5;

	logic [7:0] c0, c1, c2;
	logic [7:0] o0, o1, o2;

	assign xprod = 30'(in_s4.v) * 30'(rhr_pkg::X_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			x_s5      <= xprod[rhr_pkg::X_SHIFT +: 8];
			px_s5     <= in_s4.px;
			mn_s5     <= in_s4.mn;
			d_s5      <= in_s4.d;
			sector_s5 <= in_s4.sector;
			bypass_s5 <= in_s4.bypass;
		end
	end

	always_comb begin
		case (sector_s5)
			rhr_pkg::SEC_RED_YELLOW: begin
				c0 = d_s5; c1 = x_s5; c2 = 8'd0;
			end
			rhr_pkg::SEC_YELLOW_GREEN: begin
				c0 = x_s5; c1 = d_s5; c2 = 8'd0;
			end
			rhr_pkg::SEC_GREEN_CYAN: begin
				c0 = 8'd0; c1 = d_s5; c2 = x_s5;
			end
			rhr_pkg::SEC_CYAN_BLUE: begin
				c0 = 8'd0; c1 = x_s5; c2 = d_s5;
			end
			rhr_pkg::SEC_BLUE_MAGENTA: begin
				c0 = x_s5; c1 = 8'd0; c2 = d_s5;
			end
			default: begin
				c0 = d_s5; c1 = 8'd0; c2 = x_s5;
			end
		endcase
		o0 = c0 + mn_s5;
		o1 = c1 + mn_s5;
		o2 = c2 + mn_s5;
	end

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			if (bypass_s5) pixel_s6 <= px_s5;
			else           pixel_s6 <= {o0[7:3], o1[7:3], o2[7:3], px_s5[0]};
		end
	end

endmodule

// File: src/rhr_checker.sv
// Port-level checks for the hue rotation pipeline, bound to the top level.
// Depends on rgba5551_hue_rotate.
module rhr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [15:0] pixel_out
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pixel_out))
		else $error("stalled result item changed");

	a_res_keep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(!res_stall))
		else $error("result item dropped without being taken");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input stalled while output not blocked");

	a_stall_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> $past(pix_stall) || $past(pix_valid && !pix_stall))
		else $error("input stalled with first stage empty");

endmodule

bind rgba5551_hue_rotate rhr_checker u_rhr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.pixel_out (pixel_out)
);
